[sv/aslc_pkg.sv]
// ----------------------------------------------------------------------------
// aslc_pkg
// Types, constants and the control program shared by the adaptive smoothing
// loop-current converter.
// ----------------------------------------------------------------------------
package aslc_pkg;

    localparam int FRAC_BITS  = 12;
    localparam int CUR_W      = 20;
    localparam int STORE_W    = 32;
    localparam int DIFF_W     = STORE_W + 1;
    localparam int GAIN_W     = 17;
    localparam int THRESH_W   = 19;
    localparam int DIST_W     = 15;
    localparam int STATUS_W   = 2;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 3;

    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;

    // Register reset values
    localparam logic [GAIN_W-1:0]   GAIN_LARGE_RST  = 17'd62259;
    localparam logic [GAIN_W-1:0]   GAIN_MEDIUM_RST = 17'd52429;
    localparam logic [GAIN_W-1:0]   GAIN_SMALL_RST  = 17'd6554;
    localparam logic [GAIN_W-1:0]   GAIN_TINY_RST   = 17'd3277;
    localparam logic [THRESH_W-1:0] THRESH_HIGH_RST = 19'd1024;
    localparam logic [THRESH_W-1:0] THRESH_MID_RST  = 19'd307;
    localparam logic [THRESH_W-1:0] THRESH_LOW_RST  = 19'd102;
    localparam logic signed [CUR_W-1:0] OFFSET_RST  = 20'sd358;

    // Range limits in 1/1024 mA (below 3.7 mA means c <= 3788)
    localparam logic signed [CUR_W-1:0] UNDER_LIM  = 20'sd3789;
    localparam logic signed [CUR_W-1:0] OVER_LIM   = 20'sd22528;
    localparam logic signed [CUR_W-1:0] CLAMP_LO   = 20'sd4096;
    localparam logic signed [CUR_W-1:0] CLAMP_HI   = 20'sd20480;
    localparam logic [10:0]             MM_SCALE   = 11'd1900;
    localparam logic [DIST_W-1:0]       DIST_BASE  = 15'd1600;
    localparam logic [DIST_W-1:0]       DIST_OVER  = 15'd16;

    localparam logic [STATUS_W-1:0] RS_NORMAL = 2'd0;
    localparam logic [STATUS_W-1:0] RS_UNDER  = 2'd1;
    localparam logic [STATUS_W-1:0] RS_OVER   = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_LARGE  = 3'd0,
        CFG_GAIN_MEDIUM = 3'd1,
        CFG_GAIN_SMALL  = 3'd2,
        CFG_GAIN_TINY   = 3'd3,
        CFG_THRESH_HIGH = 3'd4,
        CFG_THRESH_MID  = 3'd5,
        CFG_THRESH_LOW  = 3'd6,
        CFG_OFFSET      = 3'd7
    } cfg_idx_t;

    // Program steps
    typedef logic [2:0] step_t;
    localparam step_t ST_IDLE = 3'd0;
    localparam step_t ST_GAIN = 3'd1;
    localparam step_t ST_MUL  = 3'd2;
    localparam step_t ST_WR   = 3'd3;
    localparam step_t ST_CONV = 3'd4;
    localparam step_t ST_EMIT = 3'd5;

    typedef enum logic [1:0] {
        COND_NEXT,      // advance to the next step
        COND_WAIT_IN,   // hold until a word is accepted
        COND_NO_UPD,    // jump to target when the word carries no update
        COND_WAIT_OUT   // hold until the output register is free, then jump
    } cond_t;

    typedef struct packed {
        logic  ld;
        logic  sel;
        logic  mul;
        logic  wr;
        logic  cvc;
        logic  emit;
        cond_t cond;
        step_t target;
    } ucode_t;

    // Gated datapath enables from the sequencer
    typedef struct packed {
        logic ld;
        logic sel;
        logic mul;
        logic wr;
        logic cvc;
        logic emit;
    } dp_ctl_t;

    typedef struct packed {
        logic upd;
        logic out_free;
    } dp_stat_t;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        w = '{ld: 1'b0, sel: 1'b0, mul: 1'b0, wr: 1'b0, cvc: 1'b0, emit: 1'b0,
               cond: COND_NEXT, target: ST_IDLE};
        case (step)
            ST_IDLE: begin
                w.ld   = 1'b1;
                w.cond = COND_WAIT_IN;
            end
            ST_GAIN: begin
                w.sel    = 1'b1;
                w.cond   = COND_NO_UPD;
                w.target = ST_CONV;
            end
            ST_MUL: begin
                w.mul = 1'b1;
            end
            ST_WR: begin
                w.wr = 1'b1;
            end
            ST_CONV: begin
                w.cvc = 1'b1;
            end
            ST_EMIT: begin
                w.emit   = 1'b1;
                w.cond   = COND_WAIT_OUT;
                w.target = ST_IDLE;
            end
            default: begin
                w.cond   = COND_WAIT_OUT;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

[sv/adaptive_smoothing_loop_current_to_mm.sv]
// ----------------------------------------------------------------------------
// adaptive_smoothing_loop_current_to_mm
// Per-channel adaptive exponential smoothing of a loop current with linear
// mapping to distance, run by a six-step control program.
// ----------------------------------------------------------------------------
// Steps: an accepted word with update set passes load, gain select, multiply,
// store write, convert and emit; with update clear it jumps from gain select to convert.
// A new word is accepted only once the previous result has been emitted; the
// single gain multiplier and the stepped program serve one word at a time.
// Reset (aresetn low, synchronous): smoothed values cleared, registers back
// to their defaults, no result pending.
module adaptive_smoothing_loop_current_to_mm #(
    parameter int CHANNEL_COUNT = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [19:0] current_in, [23:20] zero
    input  logic [1:0]  s_tuser,   // [0] channel, [1] update
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [14:0] distance_mm, [34:15] smoothed_current, [39:35] zero
    output logic [1:0]  m_tuser,   // [1:0] range_status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [aslc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [aslc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import aslc_pkg::*;

    dp_ctl_t                 ctl;
    dp_stat_t                stat;
    logic [DIST_W-1:0]       dist_out;
    logic signed [CUR_W-1:0] cur_out;

    assign cfg_ready = aresetn;

    aslc_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    aslc_dp #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl),
        .stat        (stat),
        .cur_in      (signed'(s_tdata[CUR_W-1:0])),
        .chan_in     (s_tuser[0]),
        .upd_in      (s_tuser[1]),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_dist    (dist_out),
        .out_status  (m_tuser),
        .out_current (cur_out)
    );

    assign m_tdata = {5'b0, cur_out, dist_out};

endmodule

[sv/aslc_seq.sv]
// ----------------------------------------------------------------------------
// aslc_seq
// Step counter and control-store sequencer; gates each control word with its
// wait condition and resolves conditional jumps.
// ----------------------------------------------------------------------------
module aslc_seq (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  aslc_pkg::dp_stat_t stat,
    output aslc_pkg::dp_ctl_t  ctl
);
    import aslc_pkg::*;

    step_t  step_reg;
    step_t  step_next;
    ucode_t uc;
    logic   hold;
    logic   jump;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ST_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

    always_comb begin
        uc   = ucode_rom(step_reg);
        hold = ((uc.cond == COND_WAIT_IN) && !in_valid) ||
               ((uc.cond == COND_WAIT_OUT) && !stat.out_free);
        jump = ((uc.cond == COND_NO_UPD) && !stat.upd) || (uc.cond == COND_WAIT_OUT);
        if (hold) begin
            step_next = step_reg;
        end else if (jump) begin
            step_next = uc.target;
        end else begin
            step_next = step_reg + 3'd1;
        end
        in_ready = (uc.cond == COND_WAIT_IN) && aresetn;
        ctl.ld   = uc.ld   && !hold;
        ctl.sel  = uc.sel  && !hold;
        ctl.mul  = uc.mul  && !hold;
        ctl.wr   = uc.wr   && !hold;
        ctl.cvc  = uc.cvc  && !hold;
        ctl.emit = uc.emit && !hold;
    end

endmodule

[sv/aslc_dp.sv]
// ----------------------------------------------------------------------------
// aslc_dp
// Datapath: configuration registers, per-channel smoothed store, gain select,
// gain multiply, store update, offset/saturate and mm conversion with the
// output register.
// ----------------------------------------------------------------------------
module aslc_dp #(
    parameter int CHANNEL_COUNT = 2
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  aslc_pkg::dp_ctl_t                 ctl,
    output aslc_pkg::dp_stat_t                stat,
    input  logic signed [aslc_pkg::CUR_W-1:0] cur_in,
    input  logic                              chan_in,
    input  logic                              upd_in,
    input  logic                              cfg_we,
    input  logic [aslc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [aslc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [aslc_pkg::DIST_W-1:0]       out_dist,
    output logic [aslc_pkg::STATUS_W-1:0]     out_status,
    output logic signed [aslc_pkg::CUR_W-1:0] out_current
);
    import aslc_pkg::*;

    localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int PROD_W = DIFF_W + GAIN_W + 1;

    // Configuration registers
    logic [GAIN_W-1:0]         gain_large_reg, gain_medium_reg, gain_small_reg, gain_tiny_reg;
    logic [THRESH_W-1:0]       thresh_high_reg, thresh_mid_reg, thresh_low_reg;
    logic signed [CUR_W-1:0]   offset_reg;
    logic [GAIN_W-1:0]         cfg_gain;

    // Store and working registers
    logic signed [STORE_W-1:0] store_reg [CHANNEL_COUNT];
    logic [CH_W-1:0]           ch_reg;
    logic                      upd_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic [GAIN_W-1:0]         gain_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [CUR_W-1:0]   c_reg;
    logic                      out_valid_reg;
    logic [DIST_W-1:0]         dist_reg;
    logic [STATUS_W-1:0]       status_reg;
    logic signed [CUR_W-1:0]   cur_reg;

    logic [CH_W-1:0]           ch_in;
    logic signed [STORE_W-1:0] ld_rd;
    logic signed [DIFF_W-1:0]  diff_next;
    logic [DIFF_W-1:0]         mag;
    logic [GAIN_W-1:0]         gain_next;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [STORE_W-1:0] cur_rd;
    logic signed [STORE_W-1:0] store_next;
    logic signed [CUR_W:0]     c_sum;
    logic signed [CUR_W-1:0]   c_next;
    logic signed [CUR_W-1:0]   c_clamp;
    logic [14:0]               c_ofs;
    logic [24:0]               mm_prod;
    logic [DIST_W-1:0]         dist_next;
    logic [STATUS_W-1:0]       status_next;

    assign cfg_gain = (cfg_data[GAIN_W-1:0] > GAIN_ONE) ? GAIN_ONE : cfg_data[GAIN_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_large_reg  <= GAIN_LARGE_RST;
            gain_medium_reg <= GAIN_MEDIUM_RST;
            gain_small_reg  <= GAIN_SMALL_RST;
            gain_tiny_reg   <= GAIN_TINY_RST;
            thresh_high_reg <= THRESH_HIGH_RST;
            thresh_mid_reg  <= THRESH_MID_RST;
            thresh_low_reg  <= THRESH_LOW_RST;
            offset_reg      <= OFFSET_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_GAIN_LARGE:  gain_large_reg  <= cfg_gain;
                CFG_GAIN_MEDIUM: gain_medium_reg <= cfg_gain;
                CFG_GAIN_SMALL:  gain_small_reg  <= cfg_gain;
                CFG_GAIN_TINY:   gain_tiny_reg   <= cfg_gain;
                CFG_THRESH_HIGH: thresh_high_reg <= cfg_data[THRESH_W-1:0];
                CFG_THRESH_MID:  thresh_mid_reg  <= cfg_data[THRESH_W-1:0];
                CFG_THRESH_LOW:  thresh_low_reg  <= cfg_data[THRESH_W-1:0];
                CFG_OFFSET:      offset_reg      <= signed'(cfg_data);
                default: ;
            endcase
        end
    end

    // Load: difference between the scaled sample and the stored value
    assign ch_in     = (CHANNEL_COUNT > 1) ? CH_W'(chan_in) : '0;
    assign ld_rd     = store_reg[ch_in];
    assign diff_next = signed'({cur_in[CUR_W-1], cur_in, {FRAC_BITS{1'b0}}})
                       - signed'({ld_rd[STORE_W-1], ld_rd});

    // Gain select on the magnitude of the change
    always_comb begin
        mag = diff_reg[DIFF_W-1] ? DIFF_W'(-diff_reg) : DIFF_W'(diff_reg);
        if (mag > DIFF_W'({thresh_high_reg, {FRAC_BITS{1'b0}}})) begin
            gain_next = gain_large_reg;
        end else if (mag > DIFF_W'({thresh_mid_reg, {FRAC_BITS{1'b0}}})) begin
            gain_next = gain_medium_reg;
        end else if (mag >= DIFF_W'({thresh_low_reg, {FRAC_BITS{1'b0}}})) begin
            gain_next = gain_small_reg;
        end else begin
            gain_next = gain_tiny_reg;
        end
    end

    assign prod_next = PROD_W'(diff_reg) * PROD_W'(signed'({1'b0, gain_reg}));

    // Floor of the Q16 product is the arithmetic shift; wrap to store width
    assign cur_rd     = store_reg[ch_reg];
    assign store_next = cur_rd + prod_reg[STORE_W+15:16];

    // Offset and saturate
    always_comb begin
        c_sum = signed'({cur_rd[STORE_W-1], cur_rd[STORE_W-1:FRAC_BITS]})
                + signed'({offset_reg[CUR_W-1], offset_reg});
        if (c_sum[CUR_W] != c_sum[CUR_W-1]) begin
            c_next = c_sum[CUR_W] ? signed'({1'b1, {(CUR_W-1){1'b0}}})
                                  : signed'({1'b0, {(CUR_W-1){1'b1}}});
        end else begin
            c_next = c_sum[CUR_W-1:0];
        end
    end

    // Range check and linear map to 1/16 mm
    always_comb begin
        if (c_reg < CLAMP_LO) begin
            c_clamp = CLAMP_LO;
        end else if (c_reg > CLAMP_HI) begin
            c_clamp = CLAMP_HI;
        end else begin
            c_clamp = c_reg;
        end
        c_ofs   = 15'(c_clamp - CLAMP_LO);
        mm_prod = 25'(c_ofs) * 25'(MM_SCALE) + 25'd512;
        if (c_reg < UNDER_LIM) begin
            status_next = RS_UNDER;
            dist_next   = '0;
        end else if (c_reg > OVER_LIM) begin
            status_next = RS_OVER;
            dist_next   = DIST_OVER;
        end else begin
            status_next = RS_NORMAL;
            dist_next   = DIST_BASE + mm_prod[24:10];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                store_reg[i] <= '0;
            end
        end else if (ctl.wr) begin
            store_reg[ch_reg] <= store_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (ctl.ld) begin
                upd_reg <= upd_in;
            end
            if (ctl.emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld) begin
            ch_reg   <= ch_in;
            diff_reg <= diff_next;
        end
        if (ctl.sel) begin
            gain_reg <= gain_next;
        end
        if (ctl.mul) begin
            prod_reg <= prod_next;
        end
        if (ctl.cvc) begin
            c_reg <= c_next;
        end
        if (ctl.emit) begin
            dist_reg   <= dist_next;
            status_reg <= status_next;
            cur_reg    <= c_reg;
        end
    end

    assign stat.upd      = upd_reg;
    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_dist      = dist_reg;
    assign out_status    = status_reg;
    assign out_current   = cur_reg;

endmodule
